// File: hdl/uah_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uah_pkg
// Shared types and codes for the user id admission hash table: the request
// and result words, operation and status codes, and the controller command
// and status bundles.
// ----------------------------------------------------------------------------
package uah_pkg;

  // Key width.
  localparam int KEY_W  = 32;

  // Operation codes. The spare code behaves as a query.
  localparam logic [1:0] OP_ADMIT  = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_ADMITTED = 3'd0;
  localparam logic [2:0] ST_BUSY     = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_PRESENT  = 3'd5;

  // Request word.
  typedef struct packed {
    logic [1:0]       operation;
    logic [KEY_W-1:0] user_id;
  } req_t;

  // Result word.
  typedef struct packed {
    logic [2:0] status;
    logic [6:0] slot;
    logic [7:0] occupancy;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clr;        // one step of the clearing pass
    logic       latch;      // capture the request key, start the modulo
    logic       mod;        // one step of the bucket modulo
    logic       head_load;  // start the walk at the bucket head
    logic       advance;    // follow one link of the chain
    logic       alloc_rd;   // read the link of the free-list head
    logic       alloc_wr;   // link the new entry in at the chain head
    logic       unlink;     // bypass the matching entry
    logic       free_push;  // push the removed entry onto the free list
    logic       res_load;   // load the result register
    logic       res_zero;   // report slot zero
    logic [2:0] res_status; // status code to report
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic ok;        // current chain position holds an entry
    logic match;     // that entry's key equals the request key
    logic free_ok;   // the free list is not empty
  } sts_t;

endpackage

// File: hdl/uah_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uah_ctrl
// Controller state machine: clearing pass after reset, request acceptance,
// chain walk sequencing, insert and remove updates, and the result handshake.
// ----------------------------------------------------------------------------
module uah_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_op,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  uah_pkg::sts_t sts,
  output uah_pkg::cmd_t cmd
);
  import uah_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_MOD      = 4'd2;
  localparam logic [3:0] S_HEAD     = 4'd3;
  localparam logic [3:0] S_LOAD     = 4'd4;
  localparam logic [3:0] S_WALK     = 4'd5;
  localparam logic [3:0] S_ALLOC_RD = 4'd6;
  localparam logic [3:0] S_ALLOC_WR = 4'd7;
  localparam logic [3:0] S_UNLINK   = 4'd8;
  localparam logic [3:0] S_PUSH     = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [2:0] st_r, st_nxt;
  logic       zero_r, zero_nxt;
  logic       ov_r, ov_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    st_nxt    = st_r;
    zero_nxt  = zero_r;
    ov_nxt    = ov_r & out_stall;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          op_nxt    = in_op;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod = 1'b1;
        if (sts.mod_done) begin
          state_nxt = S_HEAD;
        end
      end
      // The bucket head read settles here.
      S_HEAD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.head_load = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        if (!sts.ok) begin
          // End of chain without a match.
          zero_nxt = 1'b1;
          if (op_r == OP_ADMIT && sts.free_ok) begin
            zero_nxt  = 1'b0;
            state_nxt = S_ALLOC_RD;
          end else if (op_r == OP_ADMIT) begin
            st_nxt    = ST_FULL;
            state_nxt = S_FIN;
          end else begin
            st_nxt    = ST_NOTFOUND;
            state_nxt = S_FIN;
          end
        end else if (sts.match) begin
          zero_nxt = 1'b0;
          if (op_r == OP_ADMIT) begin
            st_nxt    = ST_BUSY;
            state_nxt = S_FIN;
          end else if (op_r == OP_REMOVE) begin
            state_nxt = S_UNLINK;
          end else begin
            st_nxt    = ST_PRESENT;
            state_nxt = S_FIN;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_ALLOC_RD: begin
        cmd.alloc_rd = 1'b1;
        state_nxt    = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        st_nxt       = ST_ADMITTED;
        state_nxt    = S_FIN;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = S_PUSH;
      end
      S_PUSH: begin
        cmd.free_push = 1'b1;
        st_nxt        = ST_REMOVED;
        state_nxt     = S_FIN;
      end
      // Hand the result word over once the output register is free.
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          cmd.res_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.res_zero   = zero_r;
    cmd.res_status = st_r;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ov_r    <= 1'b0;
      op_r    <= OP_QUERY;
      st_r    <= ST_NOTFOUND;
      zero_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      op_r    <= op_nxt;
      st_r    <= st_nxt;
      zero_r  <= zero_nxt;
    end
  end

endmodule

// File: hdl/uah_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uah_dpath
// Datapath: bucket head, link and key memories, the bucket modulo,
// the chain walk registers, the free list, the use count and the result word.
// ----------------------------------------------------------------------------
module uah_dpath #(
  parameter int BUCKETS = 32,
  parameter int ENTRIES = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  uah_pkg::req_t in_word,
  input  uah_pkg::cmd_t cmd,
  output uah_pkg::sts_t sts,
  output uah_pkg::res_t out_word
);
  import uah_pkg::*;

  localparam int IW   = $clog2(ENTRIES);
  localparam int BW   = $clog2(BUCKETS);
  localparam int UW   = $clog2(ENTRIES + 1);
  localparam int MAXN = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int CLW  = $clog2(MAXN);

  // Rounded-up reciprocal of the bucket count, scaled by 2^(KEY_W + BW).
  // With this scale the quotient is exact for every key.
  localparam int               SH      = KEY_W + BW;
  localparam logic [63:0]      RECIP_W = ((64'd1 << SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS);
  localparam logic [KEY_W:0]   RECIP   = RECIP_W[KEY_W:0];

  // A link is a valid bit over an entry index.
  logic [IW:0]      bkt_mem [BUCKETS];
  logic [IW:0]      nxt_mem [ENTRIES];
  logic [KEY_W-1:0] key_mem [ENTRIES];

  logic [IW:0]       head_q, nxt_q;
  logic [KEY_W-1:0]  key_q;

  logic [KEY_W-1:0]  key_r;
  logic [BW-1:0]     rem_r, rem_nxt;
  logic [2*KEY_W:0]  prod_r;
  logic              mstep_r;
  logic [CLW-1:0]    clr_r;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic              ok_r, ok_nxt;
  logic [IW-1:0]     prev_r;
  logic              hp_r;
  logic [IW-1:0]     free_r;
  logic              free_ok_r;
  logic [UW-1:0]     used_r;
  res_t              out_r;

  logic [KEY_W-1:0]  quo;
  logic              clr_in_ent, clr_in_bkt, clr_link_ok;

  logic              nxt_we;
  logic [IW-1:0]     nxt_wa;
  logic [IW:0]       nxt_wd;
  logic              bkt_we;
  logic [BW-1:0]     bkt_wa;
  logic [IW:0]       bkt_wd;

  // Bucket index: the quotient from the registered product, then the
  // remainder by one multiply and subtract.
  assign quo     = KEY_W'(prod_r >> SH);
  assign rem_nxt = BW'(key_r - quo * KEY_W'(BUCKETS));

  // Chain position for the next cycle; it also addresses the entry reads.
  always_comb begin
    cur_nxt = cur_r;
    ok_nxt  = ok_r;
    if (cmd.head_load) begin
      cur_nxt = head_q[IW-1:0];
      ok_nxt  = head_q[IW];
    end else if (cmd.advance) begin
      cur_nxt = nxt_q[IW-1:0];
      ok_nxt  = nxt_q[IW];
    end else if (cmd.alloc_rd) begin
      cur_nxt = free_r;
    end
  end

  // Clearing pass ranges.
  assign clr_in_ent  = ({1'b0, clr_r} < (CLW + 1)'(ENTRIES));
  assign clr_in_bkt  = ({1'b0, clr_r} < (CLW + 1)'(BUCKETS));
  assign clr_link_ok = ({1'b0, clr_r} < (CLW + 1)'(ENTRIES - 1));

  // Link memory write port.
  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = cur_r;
    nxt_wd = nxt_q;
    if (cmd.clr) begin
      nxt_we = clr_in_ent;
      nxt_wa = IW'(clr_r);
      nxt_wd = clr_link_ok ? {1'b1, IW'(clr_r + CLW'(1))} : '0;
    end else if (cmd.alloc_wr) begin
      nxt_we = 1'b1;
      nxt_wd = head_q;
    end else if (cmd.unlink) begin
      nxt_we = hp_r;
      nxt_wa = prev_r;
      nxt_wd = nxt_q;
    end else if (cmd.free_push) begin
      nxt_we = 1'b1;
      nxt_wd = {free_ok_r, free_r};
    end
  end

  // Bucket head memory write port.
  always_comb begin
    bkt_we = 1'b0;
    bkt_wa = rem_r;
    bkt_wd = nxt_q;
    if (cmd.clr) begin
      bkt_we = clr_in_bkt;
      bkt_wa = BW'(clr_r);
      bkt_wd = '0;
    end else if (cmd.alloc_wr) begin
      bkt_we = 1'b1;
      bkt_wd = {1'b1, cur_r};
    end else if (cmd.unlink) begin
      bkt_we = !hp_r;
    end
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nxt_q <= nxt_mem[cur_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_wr) begin
      key_mem[cur_r] <= key_r;
    end
    key_q <= key_mem[cur_nxt];
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_wa] <= bkt_wd;
    end
    head_q <= bkt_mem[rem_r];
  end

  // Request key, reciprocal product and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_r <= in_word.user_id;
    end
    if (cmd.mod) begin
      prod_r <= (2*KEY_W + 1)'(key_r) * (2*KEY_W + 1)'(RECIP);
    end
    cur_r <= cur_nxt;
    if (cmd.advance) begin
      prev_r <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      mstep_r <= 1'b0;
      ok_r    <= 1'b0;
      hp_r    <= 1'b0;
    end else begin
      ok_r <= ok_nxt;
      if (cmd.latch) begin
        rem_r   <= '0;
        mstep_r <= 1'b0;
        hp_r    <= 1'b0;
      end else begin
        // First step forms the product, second the remainder.
        if (cmd.mod) begin
          mstep_r <= 1'b1;
          if (mstep_r) begin
            rem_r <= rem_nxt;
          end
        end
        if (cmd.advance) begin
          hp_r <= 1'b1;
        end
      end
    end
  end

  // Clearing counter, free list and use count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      free_r    <= '0;
      free_ok_r <= 1'b1;
      used_r    <= '0;
    end else begin
      if (cmd.clr) begin
        clr_r <= clr_r + CLW'(1);
      end
      if (cmd.alloc_wr) begin
        free_r    <= nxt_q[IW-1:0];
        free_ok_r <= nxt_q[IW];
        used_r    <= used_r + UW'(1);
      end else if (cmd.free_push) begin
        free_r    <= cur_r;
        free_ok_r <= 1'b1;
        if (used_r != '0) begin
          used_r <= used_r - UW'(1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r.status    <= cmd.res_status;
      out_r.slot      <= cmd.res_zero ? 7'd0 : 7'(cur_r);
      out_r.occupancy <= 8'(used_r);
    end
  end

  assign out_word     = out_r;
  assign sts.clr_done = (clr_r == CLW'(MAXN - 1));
  assign sts.mod_done = mstep_r;
  assign sts.ok       = ok_r;
  assign sts.match    = (key_q == key_r);
  assign sts.free_ok  = free_ok_r;

endmodule

// File: hdl/uid_admission_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uid_admission_hash_table
// Pool of entries keyed by user id, kept in bucket chains with a LIFO free
// list; answers admit, query and remove requests.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid, in_stall, in_word) carries one word per
//   request: an operation and a 32-bit user id. The result channel
//   (out_valid, out_stall, out_word) returns exactly one word per request:
//   status, entry slot and the occupancy after the operation.
//   One request is in work at a time. The bucket index is formed first,
//   then the chain is walked one link per cycle, with a last check at the
//   end of a chain without a match; the time to the result word grows with
//   the chain length, and an insert or a remove adds its update steps. The
//   next request can be taken in the cycle after the result word is loaded,
//   at the soonest.
//   The result sits in an output register: while the receiver stalls it the
//   block still accepts and works on the next request, and holds that one's
//   result until the register is free.
//   After reset the block runs a clearing pass over max(BUCKETS, ENTRIES)
//   addresses of the bucket and link memories, holding in_stall high.
// ----------------------------------------------------------------------------
module uid_admission_hash_table #(
  parameter int BUCKETS = 32,
  parameter int ENTRIES = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  uah_pkg::req_t in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output uah_pkg::res_t out_word
);
  import uah_pkg::*;

  cmd_t cmd;
  sts_t sts;

  uah_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_word.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  uah_dpath #(
    .BUCKETS (BUCKETS),
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

// File: hdl/uah_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uah_checker
// Port-level checks for the user id admission hash table, bound to the top
// level.
// ----------------------------------------------------------------------------
module uah_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input uah_pkg::req_t in_word,
  input logic          out_valid,
  input logic          out_stall,
  input uah_pkg::res_t out_word
);
  import uah_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Reset starts the clearing pass with no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not held off after reset");

  // Only one request is in work: an accepted word stalls the channel.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  // Failed lookups and a full pool report slot zero.
  a_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == ST_FULL || out_word.status == ST_NOTFOUND)
      |-> out_word.slot == 7'd0)
    else $error("nonzero slot on a failed request");

endmodule

bind uid_admission_hash_table uah_checker u_chk (.*);

// File: test/uid_admission_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uid_admission_hash_table_tb
// Self-checking bench for the user id admission hash table. A short directed
// run exercises the id extremes, chain heads and tails, busy, not found and
// the spare operation code. Random phases then fill the pool past full,
// churn it and drain it again, with many ids packed into one bucket so that
// the chain walks grow long. A shadow copy of the chains and the free list
// predicts every result word, and the words that come back are compared
// field by field in order.
// ----------------------------------------------------------------------------
module uid_admission_hash_table_tb;

  import uah_pkg::*;

  localparam int BUCKETS    = 32;
  localparam int ENTRIES    = 128;
  localparam int N_ITEMS    = 1250;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 3000;
  localparam int WDOG_LIMIT = 20000;
  localparam int TAIL_WAIT  = 200;

  // The fourth operation code has no name in the package; it acts as a query.
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    req_t word;
    bit   hold_back;  // wait for every answer before offering this word
  } stim_t;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_word   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  res_t out_word;

  uid_admission_hash_table #(
    .BUCKETS(BUCKETS),
    .ENTRIES(ENTRIES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // Shadow copy of the table: bucket chains, entry links, keys and free list.
  logic [6:0]  bkt_head [BUCKETS];
  logic        bkt_vld  [BUCKETS];
  logic [6:0]  ent_next [ENTRIES];
  logic        ent_nvld [ENTRIES];
  logic [31:0] ent_key  [ENTRIES];
  logic [6:0]  free_head;
  logic        free_vld;
  logic [7:0]  used;

  // Words to send, answers still awaited, and ids believed live while building.
  stim_t       pending_words [$];
  res_t        answer_q [$];
  logic [31:0] live_q [$];
  bit          live_set [logic [31:0]];
  bit          pause_next;
  logic [4:0]  hot_bkt;

  int n_in_acc = 0;
  int n_done   = 0;
  int n_fault  = 0;
  int n_status [6];
  int max_walk = 0;
  int peak_occ = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic quiet;

  // No idling on either side for a stretch in the middle of the run.
  assign quiet = (n_in_acc >= 700) && (n_in_acc < 950);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walk the chain of the id's bucket and apply the operation to the shadow.
  function automatic res_t hash_table_answer(req_t rq);
    logic [4:0] bkt;
    logic [6:0] cur, prev, slot;
    logic       ok, hit, has_prev;
    int         steps;
    res_t       ans;
    bkt      = rq.user_id[4:0];
    ok       = bkt_vld[bkt];
    cur      = bkt_head[bkt];
    prev     = '0;
    slot     = '0;
    hit      = 1'b0;
    has_prev = 1'b0;
    steps    = 0;
    while (ok && !hit && steps < ENTRIES) begin
      if (ent_key[cur] == rq.user_id) begin
        hit  = 1'b1;
        slot = cur;
      end else begin
        prev     = cur;
        has_prev = 1'b1;
        ok       = ent_nvld[cur];
        cur      = ent_next[cur];
        steps++;
      end
    end
    if (steps > max_walk) max_walk = steps;

    case (rq.operation)
      OP_ADMIT: begin
        if (hit) begin
          ans.status = ST_BUSY;
        end else if (!free_vld) begin
          ans.status = ST_FULL;
          slot = '0;
        end else begin
          slot           = free_head;
          free_vld       = ent_nvld[slot];
          free_head      = ent_next[slot];
          ent_key[slot]  = rq.user_id;
          ent_next[slot] = bkt_head[bkt];
          ent_nvld[slot] = bkt_vld[bkt];
          bkt_head[bkt]  = slot;
          bkt_vld[bkt]   = 1'b1;
          used++;
          ans.status = ST_ADMITTED;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          if (has_prev) begin
            ent_next[prev] = ent_next[slot];
            ent_nvld[prev] = ent_nvld[slot];
          end else begin
            bkt_head[bkt] = ent_next[slot];
            bkt_vld[bkt]  = ent_nvld[slot];
          end
          ent_next[slot] = free_head;
          ent_nvld[slot] = free_vld;
          free_head      = slot;
          free_vld       = 1'b1;
          if (used > 0) used--;
          ans.status = ST_REMOVED;
        end else begin
          ans.status = ST_NOTFOUND;
          slot = '0;
        end
      end
      default: begin
        // Query, and the spare code which behaves as one.
        if (hit) begin
          ans.status = ST_PRESENT;
        end else begin
          ans.status = ST_NOTFOUND;
          slot = '0;
        end
      end
    endcase
    if (used > peak_occ) peak_occ = used;
    ans.slot      = slot;
    ans.occupancy = used;
    return ans;
  endfunction

  task automatic report_fault(string what);
    n_fault++;
    if (n_fault <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // An id that is not live at this point of the sequence; a hot one shares
  // the current crowded bucket.
  function automatic logic [31:0] fresh_key(bit hot);
    logic [31:0] k;
    do begin
      k = $urandom();
      if (hot) k[4:0] = hot_bkt;
    end while (live_set.exists(k));
    return k;
  endfunction

  function automatic logic [31:0] pick_live();
    if (live_q.size() == 0) return fresh_key(1'b0);
    return live_q[$urandom_range(live_q.size() - 1)];
  endfunction

  // Queue one request and keep the set of live ids in step with it.
  task automatic queue_request(logic [1:0] op, logic [31:0] key);
    stim_t s;
    s.word.operation = op;
    s.word.user_id   = key;
    s.hold_back      = pause_next;
    pause_next       = 1'b0;
    pending_words.push_back(s);
    if (op == OP_ADMIT && !live_set.exists(key) && live_q.size() < ENTRIES) begin
      live_set[key] = 1'b1;
      live_q.push_back(key);
    end else if (op == OP_REMOVE && live_set.exists(key)) begin
      live_set.delete(key);
      for (int i = 0; i < live_q.size(); i++) begin
        if (live_q[i] == key) begin
          live_q.delete(i);
          break;
        end
      end
    end
  endtask

  // Sender: offers queued words, idles at random, holds a word until taken.
  always @(posedge clk) begin
    logic  fire, take;
    stim_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && !in_stall;
      take = 1'b0;
      if ((!in_valid || fire) && pending_words.size() > 0) begin
        if (pending_words[0].hold_back) begin
          take = !fire && (n_in_acc == n_done);
        end else begin
          take = quiet || ($urandom_range(99) >= 19);
        end
      end
      if (take) begin
        nxt = pending_words.pop_front();
        in_word <= nxt.word;
      end
      in_valid <= take || (in_valid && !fire);
    end
  end

  // Receiver: random stalls, one long hold-off while the sender keeps going.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_in_acc >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 19);
    end
  end

  // Monitor: check each result word first, then predict for a taken request.
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report_fault($sformatf("unexpected word status %0d slot %0d occupancy %0d",
                                 out_word.status, out_word.slot, out_word.occupancy));
        end else begin
          want = answer_q.pop_front();
          if (out_word.status !== want.status || out_word.slot !== want.slot ||
              out_word.occupancy !== want.occupancy) begin
            report_fault($sformatf(
              "word %0d: expected status %0d slot %0d occupancy %0d, got %0d %0d %0d",
              n_done, want.status, want.slot, want.occupancy,
              out_word.status, out_word.slot, out_word.occupancy));
          end
        end
        n_done <= n_done + 1;
      end
      if (in_valid && !in_stall) begin
        want = hash_table_answer(in_word);
        n_status[want.status]++;
        answer_q.push_back(want);
        n_in_acc <= n_in_acc + 1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles.", WDOG_LIMIT);
        $display("uid_admission_hash_table_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int r, phase;

    // Shadow table after reset: all chains empty, every entry on the free list.
    for (int i = 0; i < BUCKETS; i++) begin
      bkt_head[i] = '0;
      bkt_vld[i]  = 1'b0;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      ent_next[i] = (i + 1 < ENTRIES) ? 7'(i + 1) : 7'd0;
      ent_nvld[i] = (i + 1 < ENTRIES);
      ent_key[i]  = '0;
    end
    free_head = '0;
    free_vld  = 1'b1;
    used      = '0;
    for (int i = 0; i < 6; i++) n_status[i] = 0;
    pause_next = 1'b0;

    // Directed: id extremes, a two-entry chain, head and tail removal,
    // busy, not found and the spare operation code.
    queue_request(OP_ADMIT,  32'h0000_0000);
    queue_request(OP_ADMIT,  32'hFFFF_FFFF);
    queue_request(OP_ADMIT,  32'h0000_0020);
    queue_request(OP_ADMIT,  32'h0000_0000);
    queue_request(OP_QUERY,  32'h0000_0020);
    queue_request(OP_QUERY,  32'h0000_0000);
    queue_request(OP_QUERY,  32'hFFFF_FFFF);
    queue_request(OP_SPARE,  32'h0000_0020);
    queue_request(OP_QUERY,  32'h0000_0040);
    queue_request(OP_REMOVE, 32'h0000_0000);
    queue_request(OP_REMOVE, 32'h0000_0000);
    queue_request(OP_REMOVE, 32'h0000_0020);
    queue_request(OP_ADMIT,  32'h8000_0000);
    queue_request(OP_SPARE,  32'h1234_5678);
    queue_request(OP_REMOVE, 32'hFFFF_FFFF);
    queue_request(OP_QUERY,  32'hFFFF_FFFF);
    queue_request(OP_REMOVE, 32'h8000_0000);

    // Random phases: fill past full, churn, then drain; each drain starts
    // with the sender waiting for every answer.
    pause_next = 1'b1;
    phase = 0;
    while (pending_words.size() < N_ITEMS) begin
      hot_bkt = 5'($urandom_range(BUCKETS - 1));
      case (phase % 3)
        0: begin
          repeat (230) begin
            r = $urandom_range(99);
            if (r < 80)      queue_request(OP_ADMIT, fresh_key(r < 45));
            else if (r < 86) queue_request(OP_ADMIT, pick_live());
            else if (r < 93) queue_request(OP_QUERY, pick_live());
            else if (r < 97) queue_request(OP_QUERY, fresh_key(1'b1));
            else             queue_request(OP_REMOVE, fresh_key(1'b0));
          end
        end
        1: begin
          repeat (150) begin
            r = $urandom_range(99);
            if (r < 30)      queue_request(OP_ADMIT, fresh_key(r < 10));
            else if (r < 50) queue_request(OP_REMOVE, pick_live());
            else if (r < 65) queue_request(OP_QUERY, pick_live());
            else if (r < 75) queue_request(OP_QUERY, fresh_key(1'b1));
            else if (r < 85) queue_request(OP_REMOVE, fresh_key(1'b0));
            else if (r < 95) queue_request(OP_SPARE, (r < 90) ? pick_live() : fresh_key(1'b0));
            else             queue_request(OP_ADMIT, pick_live());
          end
        end
        default: begin
          pause_next = 1'b1;
          repeat (200) begin
            r = $urandom_range(99);
            if (r < 75)      queue_request(OP_REMOVE, pick_live());
            else if (r < 85) queue_request(OP_REMOVE, fresh_key(1'b1));
            else if (r < 95) queue_request(OP_QUERY, pick_live());
            else             queue_request(OP_SPARE, pick_live());
          end
        end
      endcase
      phase++;
    end

    // Cut the last phase short so that the run sends the planned number of words.
    while (pending_words.size() > N_ITEMS) pending_words.delete(pending_words.size() - 1);

    // Hold reset, then release it.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word has gone and every answer has come back.
    @(negedge clk);
    while (pending_words.size() > 0 || in_valid || n_done != n_in_acc) @(negedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (answer_q.size() > 0) begin
      report_fault($sformatf("%0d answers never arrived", answer_q.size()));
    end

    $display(
      "Covered %0d requests: %0d admitted, %0d busy, %0d full, %0d removed, %0d missing, %0d present.",
      n_in_acc, n_status[ST_ADMITTED], n_status[ST_BUSY], n_status[ST_FULL],
      n_status[ST_REMOVED], n_status[ST_NOTFOUND], n_status[ST_PRESENT]);
    $display("Longest chain walk %0d links, peak occupancy %0d, %0d faults.",
             max_walk, peak_occ, n_fault);
    if (n_fault == 0) begin
      $display("uid_admission_hash_table_tb passed");
    end else begin
      $display("uid_admission_hash_table_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/uah_pkg.sv
hdl/uah_ctrl.sv
hdl/uah_dpath.sv
hdl/uid_admission_hash_table.sv
hdl/uah_checker.sv
test/uid_admission_hash_table_tb.sv
